[hw/rtl/olie_pkg.sv]
`timescale 1ns / 1ps

package olie_pkg;

  localparam int LEN_W = 8;
  localparam int VAL_W = 32;
  localparam int SIZE_W = 16;

  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_EXT_FIRST = 3'd3,
    OP_EXT_LAST  = 3'd4,
    OP_EXT_AT    = 3'd5,
    OP_READ_AT   = 3'd6,
    OP_CLEAR     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_ZERO  = 3'd2,
    ST_RANGE = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_GRAB,
    S_DN_RD,
    S_DN_WR
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // One write and one read per cycle; addresses carry the full length width.
  typedef struct packed {
    logic             we;
    logic [LEN_W-1:0] waddr;
    entry_t           wdata;
    logic [LEN_W-1:0] raddr;
  } mem_req_t;

endpackage

[hw/rtl/olie_mem.sv]
`timescale 1ns / 1ps

module olie_mem #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  olie_pkg::mem_req_t  req,
  output olie_pkg::entry_t    rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  olie_pkg::entry_t mem [DEPTH];

  // Registered read.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.raddr[AW-1:0]];
  end

endmodule

[hw/rtl/olie_ctrl.sv]
`timescale 1ns / 1ps

module olie_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [2:0]                     opcode,
  input  logic [olie_pkg::LEN_W-1:0]     position,
  input  logic [olie_pkg::VAL_W-1:0]     value,
  input  logic [olie_pkg::SIZE_W-1:0]    byte_count,
  input  logic [olie_pkg::LEN_W-1:0]     cap,
  input  olie_pkg::entry_t               rdata,
  output olie_pkg::mem_req_t             req,
  output logic                           busy,
  output logic                           done,
  output logic [2:0]                     status,
  output logic [olie_pkg::VAL_W-1:0]     out_value,
  output logic [olie_pkg::SIZE_W-1:0]    out_size,
  output logic [olie_pkg::LEN_W-1:0]     length,
  output logic                           is_empty,
  output logic                           is_full
);

  localparam int LW = olie_pkg::LEN_W;

  olie_pkg::state_t  state, state_next;
  olie_pkg::op_t     op, op_next, op_in;
  olie_pkg::entry_t  ent, ent_next;
  olie_pkg::status_t res_status, res_status_next;
  logic [LW-1:0]     len, len_next;
  logic [LW-1:0]     idx, idx_next;
  logic [LW-1:0]     p, p_next;
  logic [olie_pkg::VAL_W-1:0]  res_value, res_value_next;
  logic [olie_pkg::SIZE_W-1:0] res_size, res_size_next;
  logic              res_full, res_full_next;
  logic              done_next;
  logic              fin;
  logic [LW-1:0]     fin_len;
  logic [LW-1:0]     ins_pos, ext_pos;
  logic [LW-1:0]     idx_dec, idx_inc;
  logic [LW:0]       idx_inc_w, idx_inc2_w, len_w;

  assign op_in    = olie_pkg::op_t'(opcode);
  assign idx_dec  = idx - LW'(1);
  assign idx_inc  = idx + LW'(1);
  assign idx_inc_w  = {1'b0, idx} + (LW+1)'(1);
  assign idx_inc2_w = {1'b0, idx} + (LW+1)'(2);
  assign len_w    = {1'b0, len};

  always_comb begin
    ins_pos = (position < len) ? position : len;
    case (op_in)
      olie_pkg::OP_INS_FIRST: ins_pos = '0;
      olie_pkg::OP_INS_LAST:  ins_pos = len;
      default:                ;
    endcase
  end

  always_comb begin
    ext_pos = position;
    case (op_in)
      olie_pkg::OP_EXT_FIRST: ext_pos = '0;
      olie_pkg::OP_EXT_LAST:  ext_pos = len - LW'(1);
      default:                ;
    endcase
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    ent_next        = ent;
    len_next        = len;
    idx_next        = idx;
    p_next          = p;
    res_status_next = res_status;
    res_value_next  = res_value;
    res_size_next   = res_size;
    res_full_next   = res_full;
    done_next       = 1'b0;
    fin             = 1'b0;
    fin_len         = len;
    req.we          = 1'b0;
    req.waddr       = idx;
    req.wdata       = rdata;
    req.raddr       = idx;

    unique case (state)
      olie_pkg::S_IDLE: begin
        if (start) begin
          op_next         = op_in;
          ent_next.value  = value;
          ent_next.size   = byte_count;
          res_status_next = olie_pkg::ST_OK;
          res_value_next  = '0;
          res_size_next   = '0;
          unique case (op_in) inside
            olie_pkg::OP_INS_FIRST, olie_pkg::OP_INS_LAST, olie_pkg::OP_INS_AT: begin
              if (byte_count == '0) begin
                res_status_next = olie_pkg::ST_ZERO;
                fin = 1'b1;
              end else if (len >= cap) begin
                res_status_next = olie_pkg::ST_FULL;
                fin = 1'b1;
              end else if (op_in == olie_pkg::OP_INS_AT && position > cap) begin
                res_status_next = olie_pkg::ST_RANGE;
                fin = 1'b1;
              end else begin
                p_next     = ins_pos;
                idx_next   = len;
                state_next = (len > ins_pos) ? olie_pkg::S_UP_RD : olie_pkg::S_PUT;
              end
            end
            olie_pkg::OP_EXT_FIRST, olie_pkg::OP_EXT_LAST, olie_pkg::OP_EXT_AT,
            olie_pkg::OP_READ_AT: begin
              if (len == '0) begin
                res_status_next = olie_pkg::ST_EMPTY;
                fin = 1'b1;
              end else if (op_in == olie_pkg::OP_EXT_AT &&
                           (position >= len || position >= cap)) begin
                res_status_next = olie_pkg::ST_RANGE;
                fin = 1'b1;
              end else if (op_in == olie_pkg::OP_READ_AT && position >= len) begin
                res_status_next = olie_pkg::ST_RANGE;
                fin = 1'b1;
              end else begin
                p_next      = ext_pos;
                idx_next    = ext_pos;
                req.raddr   = ext_pos;
                state_next  = olie_pkg::S_GRAB;
              end
            end
            olie_pkg::OP_CLEAR: begin
              fin     = 1'b1;
              fin_len = '0;
            end
          endcase
        end
      end
      olie_pkg::S_UP_RD: begin
        req.raddr  = idx_dec;
        state_next = olie_pkg::S_UP_WR;
      end
      olie_pkg::S_UP_WR: begin
        req.we     = 1'b1;
        req.waddr  = idx;
        req.wdata  = rdata;
        idx_next   = idx_dec;
        state_next = (idx_dec > p) ? olie_pkg::S_UP_RD : olie_pkg::S_PUT;
      end
      olie_pkg::S_PUT: begin
        req.we    = 1'b1;
        req.waddr = p;
        req.wdata = ent;
        fin       = 1'b1;
        fin_len   = len + LW'(1);
      end
      olie_pkg::S_GRAB: begin
        res_value_next = rdata.value;
        res_size_next  = rdata.size;
        if (op == olie_pkg::OP_READ_AT) begin
          fin = 1'b1;
        end else if (idx_inc_w < len_w) begin
          state_next = olie_pkg::S_DN_RD;
        end else begin
          fin     = 1'b1;
          fin_len = len - LW'(1);
        end
      end
      olie_pkg::S_DN_RD: begin
        req.raddr  = idx_inc;
        state_next = olie_pkg::S_DN_WR;
      end
      olie_pkg::S_DN_WR: begin
        req.we    = 1'b1;
        req.waddr = idx;
        req.wdata = rdata;
        idx_next  = idx_inc;
        if (idx_inc2_w < len_w) begin
          state_next = olie_pkg::S_DN_RD;
        end else begin
          fin     = 1'b1;
          fin_len = len - LW'(1);
        end
      end
      default: state_next = olie_pkg::S_IDLE;
    endcase

    if (fin) begin
      state_next    = olie_pkg::S_IDLE;
      done_next     = 1'b1;
      len_next      = fin_len;
      res_full_next = (fin_len >= cap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= olie_pkg::S_IDLE;
      len   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    ent        <= ent_next;
    idx        <= idx_next;
    p          <= p_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    res_size   <= res_size_next;
    res_full   <= res_full_next;
  end

  assign busy      = (state != olie_pkg::S_IDLE);
  assign status    = res_status;
  assign out_value = res_value;
  assign out_size  = res_size;
  assign length    = len;
  assign is_empty  = (len == '0);
  assign is_full   = res_full;

endmodule

[hw/rtl/ordered_list_insert_extract.sv]
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// command   start, busy             opcode, position, value, byte_count
// result    done (one-cycle strobe) status, out_value, out_size, length,
//                                   is_empty, is_full
// config    cfg_valid, cfg_ready    cfg_data (capacity)
//
// A transaction is taken when start is high and busy is low. Checks that
// fail and clear strobe done in the cycle right after the accepting edge.
// Every entry that moves is read and then written back on the entry memory:
// an insert shifts up the entries from pos to the end, an extract shifts
// down those above pos. A new command is taken in the strobe cycle.
// Synchronous reset empties the list and sets capacity to 16; entry memory is
// not cleared. The receiver cannot stall: each result shows for one cycle.
module ordered_list_insert_extract #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // command transaction
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  opcode,
  input  logic [7:0]                  position,
  input  logic [31:0]                 value,
  input  logic [15:0]                 byte_count,
  // configuration write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_data,
  // result transaction
  output logic                        done,
  output logic [2:0]                  status,
  output logic [31:0]                 out_value,
  output logic [15:0]                 out_size,
  output logic [7:0]                  length,
  output logic                        is_empty,
  output logic                        is_full
);

  localparam int LW = olie_pkg::LEN_W;

  logic [LW-1:0]      capacity;
  logic [LW-1:0]      cap;
  olie_pkg::mem_req_t req;
  olie_pkg::entry_t   rdata;

  // Take capacity only between transactions.
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= LW'(16);
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Clamp the programmed capacity to the built depth.
  assign cap = (capacity < LW'(DEPTH)) ? capacity : LW'(DEPTH);

  // Sequencer: checks the command, walks the shift one entry at a time with
  // read then write back, and holds the result for its strobe. A read whose
  // data is used never shares a cycle with a write, so no bypass is needed.
  olie_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .opcode     (opcode),
    .position   (position),
    .value      (value),
    .byte_count (byte_count),
    .cap        (cap),
    .rdata      (rdata),
    .req        (req),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .out_value  (out_value),
    .out_size   (out_size),
    .length     (length),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  // Entry store: data word and size tag side by side.
  olie_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // The result strobe always comes with the sequencer back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  // An accepted command either strobes next cycle or keeps the sequencer busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command dropped");

  // The list never grows past the built depth.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LW'(DEPTH))
    else $error("length beyond depth");

  // Every write lands inside the built depth.
  a_write_in_depth: assert property (@(posedge clk) disable iff (rst)
    req.we |-> (req.waddr < LW'(DEPTH)))
    else $error("memory write beyond depth");

endmodule
